FILE: sv/pad_pkg.sv
// shared constants, register indexes and the reciprocal lookup table of the phase angle dimmer
package pad_pkg;

	// default width of the sequencer phase timer
	localparam int unsigned TIMER_BITS_DEF = 14;

	// configuration port shape
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 14;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_WIDTH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_LEVEL   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEVEL   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM     = 3'd5;

	// configuration reset values
	localparam logic [13:0] HALF_PERIOD_RST = 14'd10000;
	localparam logic [13:0] PULSE_WIDTH_RST = 14'd2000;
	localparam logic [6:0]  MIN_LEVEL_RST   = 7'd20;
	localparam logic [6:0]  MAX_LEVEL_RST   = 7'd100;
	localparam logic [4:0]  HOLDOFF_RST     = 5'd20;
	localparam logic [7:0]  CONFIRM_RST     = 8'd10;

	// brightness reset value
	localparam logic [6:0] LEVEL_RST = 7'd20;

	// brightness step thresholds and sizes
	localparam logic [6:0] STEP_FINE_BELOW = 7'd30;
	localparam logic [6:0] STEP_MID_BELOW  = 7'd50;
	localparam logic [3:0] STEP_FINE       = 4'd1;
	localparam logic [3:0] STEP_MID        = 4'd3;
	localparam logic [3:0] STEP_COARSE     = 4'd10;
	localparam int unsigned FULL_LEVEL     = 100;

	// reciprocal table: gap = (half_period * RECIP_TABLE[level]) >> RECIP_SHIFT
	localparam int unsigned RECIP_SHIFT = 21;
	typedef logic [RECIP_SHIFT-1:0] recip_t;
	typedef recip_t [127:0] recip_table_t;

	// ceil((100 - level) * 2^shift / 100), zero where no gap is timed
	function automatic recip_table_t build_recip();
		recip_table_t tab;
		int unsigned num;
		for (int i = 0; i < 128; i++) begin
			if (i == 0 || i >= FULL_LEVEL) begin
				tab[i] = '0;
			end else begin
				num = 32'((FULL_LEVEL - i) * (1 << RECIP_SHIFT) + FULL_LEVEL - 1);
				tab[i] = recip_t'(num / FULL_LEVEL);
			end
		end
		return tab;
	endfunction

	localparam recip_table_t RECIP_TABLE = build_recip();

	// button step size for a given brightness
	function automatic logic [3:0] step_of(input logic [6:0] lv);
		if (lv < STEP_FINE_BELOW) begin
			return STEP_FINE;
		end else if (lv < STEP_MID_BELOW) begin
			return STEP_MID;
		end
		return STEP_COARSE;
	endfunction

endpackage

FILE: sv/phase_angle_dimmer.sv
// top level of the phase angle dimmer: buttons, zero-cross confirm and gate sequencer
//
// One input item is one microsecond tick of the zero-cross pin and the two
// active-low buttons, taken on in_valid/in_ready. Each item yields exactly one
// result item (gate_drive, brightness) on out_valid/out_ready.
// The result of an item sits in the output register in the cycle after it is
// accepted. Throughput is one item per cycle while results are taken; all the
// work of a tick is done between the state registers and the output register,
// with the gap length formed by one 14 x 21 bit multiply of registered values.
// If the receiver stalls, the result is held and in_ready drops until it is
// taken; the next item is accepted in the same cycle the result drains.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and writes one register per handshake; unused indexes are
// dropped. Write it only while the block is idle.
// Reset loads the register defaults, sets brightness to 20 percent, clears the
// hold-off, puts the sequencer in idle and empties the output register.
module phase_angle_dimmer
	import pad_pkg::*;
#(
	parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   zero_cross_level,
	input  logic                   button_down_n,
	input  logic                   button_up_n,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   gate_drive,
	output logic [6:0]             brightness,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_CONFIRM = 3'd1;
	localparam logic [2:0] PH_GAP     = 3'd2;
	localparam logic [2:0] PH_PULSE1  = 3'd3;
	localparam logic [2:0] PH_SPACE   = 3'd4;
	localparam logic [2:0] PH_PULSE2  = 3'd5;
	localparam logic [2:0] PH_REST    = 3'd6;

	localparam int unsigned TIMER_MAX = (1 << TIMER_BITS) - 1;
	localparam int unsigned PROD_W    = 14 + RECIP_SHIFT;

	typedef logic [TIMER_BITS-1:0] timer_t;

	// saturating load of the phase timer
	function automatic timer_t timer_sat(input logic [13:0] v);
		if (32'(v) > TIMER_MAX) begin
			return '1;
		end
		return TIMER_BITS'(v);
	endfunction

	// configuration registers
	logic [13:0] half_period_q;
	logic [13:0] pulse_width_q;
	logic [6:0]  min_level_q;
	logic [6:0]  max_level_q;
	logic [4:0]  holdoff_cfg_q;
	logic [7:0]  confirm_q;

	// block state
	logic [6:0] level_q;
	logic [4:0] holdoff_q;
	logic       prev_cross_q;
	logic [2:0] phase_q;
	timer_t     timer_q;
	logic       gap_first_q;
	recip_t     recip_q;

	// output register
	logic       out_valid_q;
	logic       gate_q;
	logic [6:0] bright_q;

	logic       in_fire;
	timer_t     pulse_load;
	timer_t     space_load;
	timer_t     half_load;
	timer_t     gap_load;
	logic [PROD_W-1:0] gap_prod;

	logic [6:0] btn_level;
	logic [4:0] btn_hold;
	logic [3:0] dn_step;
	logic [7:0] up_sum;

	logic [6:0] cc_level_src;
	logic [4:0] cc_hold_src;
	logic [4:0] cc_hold;
	logic [2:0] cc_phase;
	timer_t     cc_timer;
	logic       cc_gap_first;

	logic [6:0] level_d;
	logic [4:0] hold_d;
	logic       prev_d;
	logic [2:0] phase_d;
	timer_t     timer_d;
	logic       gap_first_d;
	logic       gate_d;
	timer_t     conf_t;
	logic [2:0] ch_phase;
	timer_t     ch_timer;
	logic [6:0] level_next;

	// handshakes
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign out_valid  = out_valid_q;
	assign gate_drive = gate_q;
	assign brightness = bright_q;

	// phase lengths from configuration
	assign pulse_load = timer_sat(pulse_width_q);
	assign space_load = timer_sat(half_period_q > pulse_width_q ?
		half_period_q - pulse_width_q : 14'd0);
	assign half_load  = timer_sat(half_period_q);

	// firing gap from the registered reciprocal of the current level
	assign gap_prod = PROD_W'(half_period_q) * PROD_W'(recip_q);
	assign gap_load = timer_sat(gap_prod[PROD_W-1:RECIP_SHIFT]);

	// button scan: down first, then up on the new level
	always_comb begin
		btn_level = level_q;
		btn_hold  = holdoff_q;
		dn_step   = step_of(level_q);
		up_sum    = '0;
		if (holdoff_q == '0) begin
			if (!button_down_n) begin
				if ({1'b0, level_q} < 8'(dn_step) + {1'b0, min_level_q}) begin
					btn_level = '0;
				end else begin
					btn_level = level_q - 7'(dn_step);
				end
				btn_hold = holdoff_cfg_q;
			end
			if (!button_up_n) begin
				up_sum = {1'b0, btn_level} + 8'(step_of(btn_level));
				if (up_sum < {1'b0, min_level_q}) begin
					btn_level = min_level_q;
				end else if (up_sum > {1'b0, max_level_q}) begin
					btn_level = max_level_q;
				end else begin
					btn_level = up_sum[6:0];
				end
				btn_hold = holdoff_cfg_q;
			end
		end
	end

	// confirmed crossing: hold-off countdown and choice of gap or rest
	always_comb begin
		cc_level_src = (phase_q == PH_IDLE) ? btn_level : level_q;
		cc_hold_src  = (phase_q == PH_IDLE) ? btn_hold : holdoff_q;
		cc_hold      = (cc_hold_src != '0) ? cc_hold_src - 5'd1 : '0;
		if (cc_level_src != '0) begin
			cc_phase     = PH_GAP;
			cc_timer     = timer_q;
			cc_gap_first = 1'b1;
		end else begin
			cc_phase     = PH_REST;
			cc_timer     = half_load;
			cc_gap_first = 1'b0;
		end
	end

	// sequencer next state for one tick
	always_comb begin
		level_d     = level_q;
		hold_d      = holdoff_q;
		prev_d      = prev_cross_q;
		phase_d     = phase_q;
		timer_d     = timer_q;
		gap_first_d = gap_first_q;
		gate_d      = 1'b0;
		conf_t      = timer_q;
		ch_phase    = phase_q;
		ch_timer    = gap_first_q ? gap_load : timer_q;
		case (phase_q)
			PH_IDLE: begin
				level_d = btn_level;
				hold_d  = btn_hold;
				prev_d  = zero_cross_level;
				if (zero_cross_level && !prev_cross_q) begin
					if (confirm_q == '0) begin
						hold_d      = cc_hold;
						phase_d     = cc_phase;
						timer_d     = cc_timer;
						gap_first_d = cc_gap_first;
					end else begin
						phase_d = PH_CONFIRM;
						timer_d = TIMER_BITS'(confirm_q);
					end
				end
			end
			PH_CONFIRM: begin
				if (timer_q != '0) begin
					conf_t = timer_q - TIMER_BITS'(1);
				end
				timer_d = conf_t;
				if (conf_t == '0) begin
					if (zero_cross_level) begin
						hold_d      = cc_hold;
						phase_d     = cc_phase;
						timer_d     = cc_timer;
						gap_first_d = cc_gap_first;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			default: begin
				// skip phases of zero length within the tick
				for (int i = 0; i < 4; i++) begin
					if (ch_phase != PH_IDLE && ch_timer == '0) begin
						case (ch_phase)
							PH_GAP: begin
								ch_phase = PH_PULSE1;
								ch_timer = pulse_load;
							end
							PH_PULSE1: begin
								ch_phase = PH_SPACE;
								ch_timer = space_load;
							end
							PH_SPACE: begin
								ch_phase = PH_PULSE2;
								ch_timer = pulse_load;
							end
							default: begin
								ch_phase = PH_IDLE;
								ch_timer = '0;
							end
						endcase
					end
				end
				if (ch_phase != PH_IDLE) begin
					gate_d   = (ch_phase == PH_PULSE1) || (ch_phase == PH_PULSE2);
					ch_timer = ch_timer - TIMER_BITS'(1);
				end
				phase_d     = ch_phase;
				timer_d     = ch_timer;
				gap_first_d = 1'b0;
			end
		endcase
	end

	assign level_next = in_fire ? level_d : level_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
			pulse_width_q <= PULSE_WIDTH_RST;
			min_level_q   <= MIN_LEVEL_RST;
			max_level_q   <= MAX_LEVEL_RST;
			holdoff_cfg_q <= HOLDOFF_RST;
			confirm_q     <= CONFIRM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HALF_PERIOD: half_period_q <= cfg_data[13:0];
				REG_PULSE_WIDTH: pulse_width_q <= cfg_data[13:0];
				REG_MIN_LEVEL:   min_level_q   <= cfg_data[6:0];
				REG_MAX_LEVEL:   max_level_q   <= cfg_data[6:0];
				REG_HOLDOFF:     holdoff_cfg_q <= cfg_data[4:0];
				REG_CONFIRM:     confirm_q     <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// block state, advanced once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= LEVEL_RST;
			holdoff_q    <= '0;
			prev_cross_q <= 1'b1;
			phase_q      <= PH_IDLE;
			timer_q      <= '0;
			gap_first_q  <= 1'b0;
			recip_q      <= RECIP_TABLE[LEVEL_RST];
		end else begin
			recip_q <= RECIP_TABLE[level_next];
			if (in_fire) begin
				level_q      <= level_d;
				holdoff_q    <= hold_d;
				prev_cross_q <= prev_d;
				phase_q      <= phase_d;
				timer_q      <= timer_d;
				gap_first_q  <= gap_first_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			gate_q   <= gate_d;
			bright_q <= level_d;
		end
	end

endmodule

FILE: sv/pad_checker.sv
// port level checker of the phase angle dimmer and its bind
module pad_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       gate_drive,
	input logic [6:0] brightness
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gate_drive) && $stable(brightness))
		else $error("stalled result changed");

	// every accepted item shows a result in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item gave no result");

	// a waiting result blocks new items
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted over a stalled result");

	// gate pulses only fire at a nonzero brightness
	a_gate_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gate_drive |-> brightness != 7'd0)
		else $error("gate pulse at zero brightness");

endmodule

bind phase_angle_dimmer pad_checker u_pad_checker (.*);

FILE: tb/sv/tb_top.sv
// self-checking testbench for the phase angle dimmer: predicts every tick and checks each result
`timescale 1ns / 1ps

module tb_top;
	import pad_pkg::*;

	localparam int unsigned TIMER_MAX   = (1 << TIMER_BITS_DEF) - 1;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	// gate sequencer phases of the predictor
	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_CONFIRM,
		SEQ_GAP,
		SEQ_PULSE1,
		SEQ_SPACE,
		SEQ_PULSE2,
		SEQ_REST
	} seq_phase_e;

	// one predicted result item
	typedef struct packed {
		logic       gate;
		logic [6:0] bright;
	} tick_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   zero_cross_level;
	logic                   button_down_n;
	logic                   button_up_n;
	logic                   out_valid;
	logic                   out_ready;
	logic                   gate_drive;
	logic [6:0]             brightness;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// predictor copy of the registers
	logic [13:0] cfg_half_period = HALF_PERIOD_RST;
	logic [13:0] cfg_pulse_width = PULSE_WIDTH_RST;
	logic [6:0]  cfg_min_level   = MIN_LEVEL_RST;
	logic [6:0]  cfg_max_level   = MAX_LEVEL_RST;
	logic [4:0]  cfg_holdoff     = HOLDOFF_RST;
	logic [7:0]  cfg_confirm     = CONFIRM_RST;

	// predictor copy of the dimmer state
	logic [6:0]                dim_level   = LEVEL_RST;
	logic [4:0]                dim_holdoff = '0;
	logic                      prev_zc     = 1'b1;
	seq_phase_e                dim_phase   = SEQ_IDLE;
	logic [TIMER_BITS_DEF-1:0] dim_timer   = '0;

	tick_result_t expected_ticks[$];
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count    = 0;
	bit           tx_idle_on     = 1'b1;
	bit           rx_idle_on     = 1'b1;
	int unsigned  rx_hold_left   = 0;
	int unsigned  rx_stall_left  = 0;

	phase_angle_dimmer i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.zero_cross_level (zero_cross_level),
		.button_down_n    (button_down_n),
		.button_up_n      (button_up_n),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.gate_drive       (gate_drive),
		.brightness       (brightness),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// every timer load saturates at the timer width
	function automatic logic [TIMER_BITS_DEF-1:0] timer_clip(input int unsigned v);
		if (v > TIMER_MAX) begin
			return TIMER_MAX[TIMER_BITS_DEF-1:0];
		end
		return v[TIMER_BITS_DEF-1:0];
	endfunction

	// brightness step for the current level
	function automatic int level_step(input int lv);
		if (lv < 30) begin
			return 1;
		end else if (lv < 50) begin
			return 3;
		end
		return 10;
	endfunction

	// idle length: mostly short, now and then long
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(12, 60);
		end
		return $urandom_range(1, 3);
	endfunction

	// confirmed crossing: count down the hold-off and load the first timed phase
	task automatic arm_firing();
		int unsigned gap;
		if (dim_holdoff != 0) begin
			dim_holdoff = dim_holdoff - 1'b1;
		end
		if (dim_level > 0) begin
			gap = 0;
			if (dim_level < 100) begin
				gap = 32'(cfg_half_period) * (32'd100 - 32'(dim_level)) / 32'd100;
			end
			dim_phase = SEQ_GAP;
			dim_timer = timer_clip(gap);
		end else begin
			dim_phase = SEQ_REST;
			dim_timer = timer_clip(cfg_half_period);
		end
	endtask

	// work out the result of one tick and advance the dimmer state
	task automatic predict_tick(input logic zc, input logic dn, input logic up,
		output tick_result_t res);
		int   lv;
		logic gate;
		gate = 1'b0;
		case (dim_phase)
		SEQ_IDLE: begin
			// buttons act only with the hold-off run out, down before up
			if (dim_holdoff == 0) begin
				lv = dim_level;
				if (!dn) begin
					lv -= level_step(lv);
					if (lv < int'(cfg_min_level)) begin
						lv = 0;
					end
					dim_holdoff = cfg_holdoff;
				end
				if (!up) begin
					lv += level_step(lv);
					if (lv < int'(cfg_min_level)) begin
						lv = int'(cfg_min_level);
					end else if (lv > int'(cfg_max_level)) begin
						lv = int'(cfg_max_level);
					end
					dim_holdoff = cfg_holdoff;
				end
				dim_level = lv[6:0];
			end
			// rising zero-cross edge
			if (zc && !prev_zc) begin
				if (cfg_confirm == 0) begin
					arm_firing();
				end else begin
					dim_phase = SEQ_CONFIRM;
					dim_timer = timer_clip(cfg_confirm);
				end
			end
			prev_zc = zc;
		end
		SEQ_CONFIRM: begin
			if (dim_timer != 0) begin
				dim_timer = dim_timer - 1'b1;
			end
			if (dim_timer == 0) begin
				if (zc) begin
					arm_firing();
				end else begin
					dim_phase = SEQ_IDLE;
				end
			end
		end
		default: begin
			// phases of zero length pass within the same tick
			while (dim_phase != SEQ_IDLE && dim_timer == 0) begin
				case (dim_phase)
				SEQ_GAP: begin
					dim_phase = SEQ_PULSE1;
					dim_timer = timer_clip(cfg_pulse_width);
				end
				SEQ_PULSE1: begin
					dim_phase = SEQ_SPACE;
					dim_timer = timer_clip(cfg_half_period > cfg_pulse_width ?
						cfg_half_period - cfg_pulse_width : 14'd0);
				end
				SEQ_SPACE: begin
					dim_phase = SEQ_PULSE2;
					dim_timer = timer_clip(cfg_pulse_width);
				end
				default: begin
					dim_phase = SEQ_IDLE;
					dim_timer = '0;
				end
				endcase
			end
			if (dim_phase != SEQ_IDLE) begin
				gate = (dim_phase == SEQ_PULSE1 || dim_phase == SEQ_PULSE2);
				dim_timer = dim_timer - 1'b1;
			end
		end
		endcase
		res.gate   = gate;
		res.bright = dim_level;
	endtask

	// offer one tick item, predict it on acceptance, then maybe idle
	task automatic send_tick(input logic zc, input logic dn, input logic up);
		tick_result_t res;
		int unsigned  idle;
		@(negedge clk);
		in_valid         <= 1'b1;
		zero_cross_level <= zc;
		button_down_n    <= dn;
		button_up_n      <= up;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_tick(zc, dn, up, res);
		expected_ticks.push_back(res);
		idle = 0;
		if (tx_idle_on && $urandom_range(0, 9) < 3) begin
			idle = idle_len();
		end
		if (idle != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
	endtask

	// drop valid and wait until every predicted result has come back
	task automatic settle();
		if (in_valid) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		while (expected_ticks.size() != 0) @(posedge clk);
	endtask

	// one register write, mirrored into the predictor
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
		REG_HALF_PERIOD: cfg_half_period = data;
		REG_PULSE_WIDTH: cfg_pulse_width = data;
		REG_MIN_LEVEL:   cfg_min_level   = data[6:0];
		REG_MAX_LEVEL:   cfg_max_level   = data[6:0];
		REG_HOLDOFF:     cfg_holdoff     = data[4:0];
		REG_CONFIRM:     cfg_confirm     = data[7:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// write the whole register set once the block has drained
	task automatic program_regs(input int unsigned hp, input int unsigned pw,
		input int unsigned lo, input int unsigned hi, input int unsigned hold,
		input int unsigned conf);
		settle();
		write_reg(REG_HALF_PERIOD, 14'(hp));
		write_reg(REG_PULSE_WIDTH, 14'(pw));
		write_reg(REG_MIN_LEVEL, 14'(lo));
		write_reg(REG_MAX_LEVEL, 14'(hi));
		write_reg(REG_HOLDOFF, 14'(hold));
		write_reg(REG_CONFIRM, 14'(conf));
	endtask

	// mains-like zero-cross waveform with button presses, glitches and some noise
	task automatic run_mains(input int unsigned count);
		logic        zc_now   = 1'b0;
		int unsigned seg_left = 0;
		int unsigned btn_mode = 0;
		bit          noise    = 1'b0;
		repeat (count) begin
			if (seg_left == 0) begin
				noise = ($urandom_range(0, 9) == 0);
				if (zc_now) begin
					zc_now   = 1'b0;
					seg_left = $urandom_range(1, 24);
				end else begin
					zc_now = 1'b1;
					// short highs are glitches that fail the recheck
					if (cfg_confirm != 0 && $urandom_range(0, 4) == 0) begin
						seg_left = $urandom_range(1, cfg_confirm);
					end else begin
						seg_left = cfg_confirm + $urandom_range(1, 12);
					end
				end
				btn_mode = $urandom_range(0, 5);
			end
			seg_left--;
			if (noise) begin
				send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else begin
				send_tick(zc_now, !(btn_mode == 3 || btn_mode == 5),
					!(btn_mode == 4 || btn_mode == 5));
			end
		end
	endtask

	// run the sequencer back to idle with quiet ticks, then drain results
	task automatic finish_phase();
		while (dim_phase != SEQ_IDLE) begin
			send_tick(1'b0, 1'b1, 1'b1);
		end
		settle();
	endtask

	// reset brightness, every button combination, immediate and delayed crossings
	task automatic test_directed();
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1);
		program_regs(20, 3, 20, 100, 0, 0);
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b1);
		finish_phase();
		program_regs(20, 3, 20, 100, 0, 2);
		// rejected crossing, then a confirmed one
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);
		finish_phase();
	endtask

	// free buttons over the whole range in fine, mid and coarse steps
	task automatic test_fine_steps();
		program_regs(30, 3, 1, 100, 0, 0);
		run_mains(50);
		finish_phase();
	endtask

	// pulse wider than the half period, longest confirm and hold-off
	task automatic test_confirm_extremes();
		program_regs(8, 12, 20, 100, 31, 255);
		run_mains(260);
		finish_phase();
	endtask

	// full level gives no gap, pulse as wide as the half period leaves no space
	task automatic test_full_level();
		program_regs(12, 12, 100, 100, 1, 3);
		run_mains(40);
		finish_phase();
	endtask

	// minimum above maximum, zero pulse width
	task automatic test_inverted_limits();
		program_regs(16, 0, 60, 40, 2, 1);
		run_mains(40);
		finish_phase();
	endtask

	// level above full and a zero half period
	task automatic test_over_full_level();
		program_regs(0, 4, 127, 127, 0, 0);
		run_mains(30);
		finish_phase();
	endtask

	// lowest level for a long gap, narrowest pulse, no idling on either side
	task automatic test_long_period();
		program_regs(40, 1, 1, 1, 0, 2);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_mains(40);
		finish_phase();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// receiver holds off while the sender keeps offering, then the sender pauses
	task automatic test_backpressure();
		program_regs(30, 5, 20, 100, 2, 3);
		tx_idle_on   = 1'b0;
		rx_hold_left = 300;
		run_mains(50);
		tx_idle_on = 1'b1;
		settle();
		run_mains(20);
		finish_phase();
	endtask

	// random register settings with short timers
	task automatic test_random_settings();
		repeat (2) begin
			program_regs($urandom_range(0, 40), $urandom_range(0, 30),
				$urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 31), $urandom_range(0, 20));
			run_mains(25);
			finish_phase();
		end
	endtask

	// result checker
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_ticks.size() == 0) begin
				$display("%0t: unexpected result item: gate_drive %0b brightness %0d",
					$time, gate_drive, brightness);
				mismatch_count++;
			end else begin
				want = expected_ticks.pop_front();
				if (gate_drive !== want.gate) begin
					$display("%0t: gate_drive expected %0b actual %0b",
						$time, want.gate, gate_drive);
					mismatch_count++;
				end
				if (brightness !== want.bright) begin
					$display("%0t: brightness expected %0d actual %0d",
						$time, want.bright, brightness);
					mismatch_count++;
				end
			end
		end
	end

	// receiver: long hold-off on request, random stalls otherwise
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_left != 0) begin
				out_ready <= 1'b0;
				rx_hold_left--;
			end else if (rx_stall_left != 0) begin
				out_ready <= 1'b0;
				rx_stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (rx_idle_on && $urandom_range(0, 9) < 2) begin
					rx_stall_left = idle_len();
				end
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// test sequence
	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		zero_cross_level = 1'b0;
		button_down_n    = 1'b1;
		button_up_n      = 1'b1;
		cfg_valid        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fine_steps();
		test_confirm_extremes();
		test_full_level();
		test_inverted_limits();
		test_over_full_level();
		test_long_period();
		test_backpressure();
		test_random_settings();

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_ticks.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
